// ===== hdl/c_source_char_metrics_macros.svh =====
// ----------------------------------------------------------------------------
// c_source_char_metrics_macros
// assertion macros for the c source metrics rtl
// ----------------------------------------------------------------------------
`ifndef C_SOURCE_CHAR_METRICS_MACROS_SVH
`define C_SOURCE_CHAR_METRICS_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define CCM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CCM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/ccm_pkg.sv =====
// ----------------------------------------------------------------------------
// ccm_pkg
// types and constants for the c source character metrics block
// ----------------------------------------------------------------------------
package ccm_pkg;

	localparam int CCM_COUNT_WIDTH = 32;
	localparam int CCM_OUT_WIDTH   = 32;
	localparam int CCM_NUM_CNT     = 7;

	// counter slots
	localparam int K_CHARS   = 0;
	localparam int K_LINES   = 1;
	localparam int K_LONGEST = 2;
	localparam int K_SPACES  = 3;
	localparam int K_LCOM    = 4;
	localparam int K_BCOM    = 5;
	localparam int K_CCHR    = 6;

	localparam logic [7:0] CH_NL     = 8'd10;
	localparam logic [7:0] CH_SLASH  = 8'd47;
	localparam logic [7:0] CH_STAR   = 8'd42;
	localparam logic [7:0] CH_QUOTE  = 8'd39;
	localparam logic [7:0] CH_DQUOTE = 8'd34;
	localparam logic [7:0] CH_BSLASH = 8'd92;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_CR     = 8'd13;

	typedef enum logic [3:0] {
		ST_NORMAL     = 4'd0,
		ST_CHR        = 4'd1,
		ST_STR        = 4'd2,
		ST_CHR_ESC    = 4'd3,
		ST_STR_ESC    = 4'd4,
		ST_SLASH      = 4'd5,
		ST_LINE_COM   = 4'd6,
		ST_BLOCK_COM  = 4'd7,
		ST_BLOCK_STAR = 4'd8
	} ccm_state_t;

	typedef struct packed {
		logic space;
		logic lcom_open;
		logic bcom_open;
		logic cchr_inc;
		logic cchr_dec;
	} ccm_event_t;

endpackage

// ===== hdl/ccm_lexer.sv =====
// ----------------------------------------------------------------------------
// ccm_lexer
// next-state function of the comment and literal lexer, with counter events
// ----------------------------------------------------------------------------
module ccm_lexer
	import ccm_pkg::*;
(
	input  ccm_state_t state,
	input  logic [7:0] char_code,
	output ccm_state_t state_next,
	output ccm_event_t events
);

	logic is_ws;

	assign is_ws = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));

	always_comb begin
		state_next = state;
		events     = '0;
		case (state)
			ST_CHR: begin
				if (char_code == CH_QUOTE) begin
					state_next = ST_NORMAL;
				end else if (char_code == CH_BSLASH) begin
					state_next = ST_CHR_ESC;
				end
			end
			ST_STR: begin
				if (char_code == CH_DQUOTE) begin
					state_next = ST_NORMAL;
				end else if (char_code == CH_BSLASH) begin
					state_next = ST_STR_ESC;
				end
			end
			ST_CHR_ESC: state_next = ST_CHR;
			ST_STR_ESC: state_next = ST_STR;
			ST_SLASH: begin
				// the byte after a lone slash is swallowed
				if (char_code == CH_SLASH) begin
					state_next       = ST_LINE_COM;
					events.lcom_open = 1'b1;
				end else if (char_code == CH_STAR) begin
					state_next       = ST_BLOCK_COM;
					events.bcom_open = 1'b1;
				end else begin
					state_next = ST_NORMAL;
				end
			end
			ST_LINE_COM: begin
				if (char_code == CH_NL) begin
					state_next = ST_NORMAL;
				end else begin
					events.cchr_inc = 1'b1;
				end
			end
			ST_BLOCK_COM: begin
				if (char_code == CH_STAR) begin
					state_next = ST_BLOCK_STAR;
				end
				events.cchr_inc = 1'b1;
			end
			ST_BLOCK_STAR: begin
				// the star was already counted, take it back on close
				if (char_code == CH_SLASH) begin
					state_next      = ST_NORMAL;
					events.cchr_dec = 1'b1;
				end else begin
					if (char_code != CH_STAR) begin
						state_next = ST_BLOCK_COM;
					end
					events.cchr_inc = 1'b1;
				end
			end
			default: begin
				state_next = ST_NORMAL;
				if (is_ws) begin
					events.space = 1'b1;
				end else if (char_code == CH_SLASH) begin
					state_next = ST_SLASH;
				end else if (char_code == CH_QUOTE) begin
					state_next = ST_CHR;
				end else if (char_code == CH_DQUOTE) begin
					state_next = ST_STR;
				end
			end
		endcase
	end

endmodule

// ===== hdl/c_source_char_metrics.sv =====
// ----------------------------------------------------------------------------
// c_source_char_metrics
// byte-wide c source lexer keeping saturating character, line and comment counts
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid / in_stall    | char_code
//  out     | source    | out_valid / out_stall  | seven counters, lexer_state
//
//  one byte per cycle sustained unless the output stalls; each byte is first captured
//  in the input register, then its counts and lexer state are registered into the
//  counter and lexer registers, which are themselves the result register
//  reset clears the lexer to normal and all counters to zero
//  a stalled output holds the input register; in_stall rises only when both are full
// ----------------------------------------------------------------------------
`include "c_source_char_metrics_macros.svh"

module c_source_char_metrics
	import ccm_pkg::*;
#(
	parameter int COUNT_WIDTH = CCM_COUNT_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               char_code,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CCM_OUT_WIDTH-1:0] chars_total,
	output logic [CCM_OUT_WIDTH-1:0] lines_total,
	output logic [CCM_OUT_WIDTH-1:0] longest_line,
	output logic [CCM_OUT_WIDTH-1:0] spaces_total,
	output logic [CCM_OUT_WIDTH-1:0] line_comments,
	output logic [CCM_OUT_WIDTH-1:0] block_comments,
	output logic [CCM_OUT_WIDTH-1:0] comment_chars,
	output logic [3:0]               lexer_state
);

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (&v) ? v : v + cnt_t'(1);
	endfunction

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_valid_q;
	logic       adv;
	logic       s1_load;

	ccm_state_t state_q;
	ccm_state_t state_next;
	ccm_event_t events;
	cnt_t       line_len_q;
	cnt_t       line_len_d;
	cnt_t       cnt_q [CCM_NUM_CNT];
	cnt_t       cnt_d [CCM_NUM_CNT];
	logic       is_nl;

	logic [CCM_OUT_WIDTH-1:0] cnt_out [CCM_NUM_CNT];

	// handshake: s1 moves into the counters whenever the output side can take it
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign s1_load  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			char_s1 <= char_code;
		end
	end

	ccm_lexer u_lexer (
		.state      (state_q),
		.char_code  (char_s1),
		.state_next (state_next),
		.events     (events)
	);

	assign is_nl = (char_s1 == CH_NL);

	always_comb begin
		for (int k = 0; k < CCM_NUM_CNT; k++) begin
			cnt_d[k] = cnt_q[k];
		end
		cnt_d[K_CHARS] = sat_inc(cnt_q[K_CHARS]);
		line_len_d     = sat_inc(line_len_q);
		if (is_nl) begin
			cnt_d[K_LINES] = sat_inc(cnt_q[K_LINES]);
			if (line_len_q > cnt_q[K_LONGEST]) begin
				cnt_d[K_LONGEST] = line_len_q;
			end
			line_len_d = '0;
		end
		if (events.space) begin
			cnt_d[K_SPACES] = sat_inc(cnt_q[K_SPACES]);
		end
		if (events.lcom_open) begin
			cnt_d[K_LCOM] = sat_inc(cnt_q[K_LCOM]);
		end
		if (events.bcom_open) begin
			cnt_d[K_BCOM] = sat_inc(cnt_q[K_BCOM]);
		end
		if (events.cchr_inc) begin
			cnt_d[K_CCHR] = sat_inc(cnt_q[K_CCHR]);
		end else if (events.cchr_dec) begin
			// floors at zero, and a saturated count stays put
			if ((cnt_q[K_CCHR] != '0) && !(&cnt_q[K_CCHR])) begin
				cnt_d[K_CCHR] = cnt_q[K_CCHR] - cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_NORMAL;
			line_len_q <= '0;
			for (int k = 0; k < CCM_NUM_CNT; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (adv) begin
			state_q    <= state_next;
			line_len_q <= line_len_d;
			for (int k = 0; k < CCM_NUM_CNT; k++) begin
				cnt_q[k] <= cnt_d[k];
			end
		end
	end

	for (genvar g = 0; g < CCM_NUM_CNT; g++) begin : g_out
		if (COUNT_WIDTH >= CCM_OUT_WIDTH) begin : g_trunc
			assign cnt_out[g] = cnt_q[g][CCM_OUT_WIDTH-1:0];
		end else begin : g_ext
			assign cnt_out[g] = {{(CCM_OUT_WIDTH-COUNT_WIDTH){1'b0}}, cnt_q[g]};
		end
	end

	assign out_valid      = out_valid_q;
	assign chars_total    = cnt_out[K_CHARS];
	assign lines_total    = cnt_out[K_LINES];
	assign longest_line   = cnt_out[K_LONGEST];
	assign spaces_total   = cnt_out[K_SPACES];
	assign line_comments  = cnt_out[K_LCOM];
	assign block_comments = cnt_out[K_BCOM];
	assign comment_chars  = cnt_out[K_CCHR];
	assign lexer_state    = 4'(state_q);

	`CCM_ASSERT_NXT(a_chars_step, clk, arst_n, adv, (cnt_q[K_CHARS] == $past(cnt_q[K_CHARS]) + cnt_t'(1)) || (&$past(cnt_q[K_CHARS])))
	`CCM_ASSERT_NXT(a_cchr_hold, clk, arst_n, !adv, $stable(cnt_q[K_CCHR]) && $stable(state_q))
	`CCM_ASSERT_NXT(a_lcom_end, clk, arst_n, adv && (state_q == ST_LINE_COM) && (char_s1 == CH_NL), state_q == ST_NORMAL)
	`CCM_ASSERT_IMP(a_stall_full, clk, arst_n, in_stall, valid_s1 && out_valid_q && out_stall)

endmodule
